// ===== hw/rtl/fekc_pkg.sv =====
// ----------------------------------------------------------------------------
// fekc_pkg
// Shared types and constants for the FIFO-evicting key cache.
// ----------------------------------------------------------------------------
`default_nettype none

package fekc_pkg;

	// Operation codes carried on the mode field
	typedef enum logic [1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Fixed field widths
	localparam int unsigned KEY_WORD_BITS = 64;
	localparam int unsigned KEY_WORDS     = 4;
	localparam int unsigned HANDLE_BITS   = 32;
	localparam int unsigned LIMIT_BITS    = 5;
	localparam int unsigned COUNT_BITS    = 5;

	// Entry limit after reset
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

	typedef logic [KEY_WORDS-1:0][KEY_WORD_BITS-1:0] key_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fifo_evicting_key_cache.sv =====
// ----------------------------------------------------------------------------
// fifo_evicting_key_cache
// Fully associative key-to-handle cache, FIFO replacement over DEPTH slots.
// done rises once the start beat has passed the input register and then the
// result register. Throughput: one beat per cycle, busy is always low.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset empties the cache and sets the entry limit to 16; slots are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_evicting_key_cache #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 cfg_wen,
	input  wire logic [fekc_pkg::LIMIT_BITS-1:0]      cfg_wdata,
	// command
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [1:0]                           mode,
	input  wire logic                                 key_empty,
	input  wire logic [fekc_pkg::KEY_WORD_BITS-1:0]   key_word0,
	input  wire logic [fekc_pkg::KEY_WORD_BITS-1:0]   key_word1,
	input  wire logic [fekc_pkg::KEY_WORD_BITS-1:0]   key_word2,
	input  wire logic [fekc_pkg::KEY_WORD_BITS-1:0]   key_word3,
	input  wire logic [fekc_pkg::HANDLE_BITS-1:0]     value_in,
	// result
	output logic                                      done,
	output logic                                      hit,
	output logic [fekc_pkg::HANDLE_BITS-1:0]          value_out,
	output logic                                      duplicate_error,
	output logic [fekc_pkg::COUNT_BITS-1:0]           entry_count
);

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = IW + 1;
	localparam int unsigned LW = (CW > fekc_pkg::LIMIT_BITS) ? CW : fekc_pkg::LIMIT_BITS;
	localparam int unsigned HANDLE_W = fekc_pkg::HANDLE_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

	// Reduce a value below twice DEPTH into the ring
	function automatic logic [IW-1:0] ring_wrap(input logic [CW-1:0] v);
		logic [CW-1:0] r;
		r = (v >= DEPTH_C) ? (v - DEPTH_C) : v;
		return r[IW-1:0];
	endfunction

	// Configuration register
	logic [fekc_pkg::LIMIT_BITS-1:0] limit_q;

	// Input stage
	logic                   valid_s1;
	fekc_pkg::mode_t        mode_s1;
	logic                   empty_s1;
	fekc_pkg::key_t         key_s1;
	logic [HANDLE_W-1:0]    value_s1;

	// Cache state
	fekc_pkg::key_t         key_q   [DEPTH];
	logic [VALUE_BITS-1:0]  value_q [DEPTH];
	logic [IW-1:0]          oldest_q;
	logic [CW-1:0]          count_q;

	// Result registers
	logic                   done_q;
	logic                   hit_q;
	logic [HANDLE_W-1:0]    value_out_q;
	logic                   dup_q;
	logic [fekc_pkg::COUNT_BITS-1:0] count_out_q;

	// Combinational results
	logic [DEPTH-1:0]       match;
	logic                   any_match;
	logic [VALUE_BITS-1:0]  match_value;
	logic [LW-1:0]          lim_ext;
	logic [CW-1:0]          lim;
	logic [IW-1:0]          old1;
	logic [CW-1:0]          cnt1;
	logic [CW-1:0]          cnt2;
	logic [CW-1:0]          drop_n;
	logic [IW-1:0]          tail;
	logic                   wr_en;
	logic [IW-1:0]          oldest_nxt;
	logic [CW-1:0]          count_nxt;
	logic                   hit_nxt;
	logic                   dup_nxt;

	assign busy = 1'b0;

	// Hold the entry limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= fekc_pkg::LIMIT_RESET;
		end else if (cfg_wen) begin
			limit_q <= cfg_wdata;
		end
	end

	// Capture the command beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			mode_s1  <= fekc_pkg::mode_t'(mode);
			empty_s1 <= key_empty;
			key_s1   <= {key_word3, key_word2, key_word1, key_word0};
			value_s1 <= value_in;
		end
	end

	// Compare every live slot against the key
	always_comb begin
		logic [CW-1:0] pos;
		match       = '0;
		match_value = '0;
		for (int s = 0; s < DEPTH; s++) begin
			pos = CW'(s) + DEPTH_C - {1'b0, oldest_q};
			if (pos >= DEPTH_C) begin
				pos = pos - DEPTH_C;
			end
			match[s] = (pos < count_q) && (key_q[s] == key_s1) && !empty_s1;
			if (match[s]) begin
				match_value = match_value | value_q[s];
			end
		end
		any_match = |match;
	end

	// Clamp the entry limit into 1..DEPTH
	always_comb begin
		lim_ext = LW'(limit_q);
		if (lim_ext == '0) begin
			lim_ext = LW'(1);
		end else if (lim_ext > DEPTH_L) begin
			lim_ext = DEPTH_L;
		end
		lim = CW'(lim_ext);
	end

	// Work out the tail slot and the eviction for an insert
	always_comb begin
		if (count_q >= DEPTH_C) begin
			old1 = ring_wrap({1'b0, oldest_q} + CW'(1));
			cnt1 = count_q - CW'(1);
		end else begin
			old1 = oldest_q;
			cnt1 = count_q;
		end
		tail   = ring_wrap({1'b0, old1} + cnt1);
		cnt2   = cnt1 + CW'(1);
		drop_n = (cnt2 > lim) ? (cnt2 - lim) : '0;
	end

	// Decode the operation into the next state and result
	always_comb begin
		wr_en      = 1'b0;
		oldest_nxt = oldest_q;
		count_nxt  = count_q;
		hit_nxt    = 1'b0;
		dup_nxt    = 1'b0;
		if (valid_s1) begin
			unique case (mode_s1)
				fekc_pkg::MODE_LOOKUP: begin
					hit_nxt = any_match;
				end
				fekc_pkg::MODE_INSERT: begin
					if (!empty_s1) begin
						if (any_match) begin
							dup_nxt = 1'b1;
						end else begin
							wr_en      = 1'b1;
							oldest_nxt = ring_wrap({1'b0, old1} + drop_n);
							count_nxt  = cnt2 - drop_n;
						end
					end
				end
				fekc_pkg::MODE_CLEAR: begin
					oldest_nxt = '0;
					count_nxt  = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Advance ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
		end else begin
			oldest_q <= oldest_nxt;
			count_q  <= count_nxt;
		end
	end

	// Write the new entry at the tail
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q[tail]   <= key_s1;
			value_q[tail] <= VALUE_BITS'(value_s1);
		end
	end

	// Register the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hit_q       <= hit_nxt;
			value_out_q <= hit_nxt ? HANDLE_W'(match_value) : '0;
			dup_q       <= dup_nxt;
			count_out_q <= fekc_pkg::COUNT_BITS'(count_nxt);
		end
	end

	assign done            = done_q;
	assign hit             = hit_q;
	assign value_out       = value_out_q;
	assign duplicate_error = dup_q;
	assign entry_count     = count_out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("live count beyond ring depth");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("key matched in more than one live slot");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done_q)
		else $error("accepted beat produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done_q)
		else $error("result without an accepted beat");

	a_hit_dup_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(hit_q && dup_q))
		else $error("hit and duplicate flagged together");

	a_write_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (count_q >= CW'(1)) && (count_q <= lim))
		else $error("insert left count outside the limit");
`endif

endmodule

`default_nettype wire
